FILE: hw/rtl/rfd_pkg.sv
// ---------------------------------------------------------------------------
// Range frame deframer package
// Shared constants and types for the range frame deframer cells and checker.
// ---------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    // Number of bytes in one sensor frame.
    localparam int WIN_LEN = 16;
    localparam int FILL_W  = $clog2(WIN_LEN + 1);

    // Frame markers and the status code that flags a usable distance.
    localparam logic [7:0] SYNC_HEADER  = 8'h57;
    localparam logic [7:0] SYNC_MARK    = 8'h00;
    localparam logic [7:0] STATUS_VALID = 8'h01;

    typedef logic [7:0] t_byte;
    typedef logic [WIN_LEN-1:0][7:0] t_window;

    // Result of the frame check on the current window.
    typedef struct packed {
        logic hdr_ok;
        logic sum_ok;
    } t_chk_status;

endpackage

`default_nettype wire

FILE: hw/rtl/rfd_cell.sv
// ---------------------------------------------------------------------------
// Range frame deframer byte cell
// Holds one byte of the window and takes its neighbor's byte on every shift.
// ---------------------------------------------------------------------------
`default_nettype none

module rfd_cell (
    input  wire logic         i_clk,
    input  wire logic         i_shift,
    input  wire rfd_pkg::t_byte i_d,
    output rfd_pkg::t_byte    o_q
);
    import rfd_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_d;
        end
    end

    assign o_q = r_byte;

endmodule

`default_nettype wire

FILE: hw/rtl/rfd_check.sv
// ---------------------------------------------------------------------------
// Range frame deframer checker
// Compares the header bytes and the 8-bit additive checksum of a window.
// ---------------------------------------------------------------------------
`default_nettype none

module rfd_check (
    input  wire rfd_pkg::t_window i_win,
    output rfd_pkg::t_chk_status  o_status
);
    import rfd_pkg::*;

    t_byte s1 [8];
    t_byte s2 [4];
    t_byte s3 [2];
    t_byte sum;

    // Four-level adder tree over bytes 0 to 14, kept modulo 256.
    always_comb begin
        for (int k = 0; k < 7; k++) begin
            s1[k] = i_win[2*k] + i_win[2*k+1];
        end
        s1[7] = i_win[14];
        for (int k = 0; k < 4; k++) begin
            s2[k] = s1[2*k] + s1[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            s3[k] = s2[2*k] + s2[2*k+1];
        end
        sum = s3[0] + s3[1];
    end

    assign o_status.hdr_ok = (i_win[0] == SYNC_HEADER) && (i_win[1] == SYNC_MARK);
    assign o_status.sum_ok = (sum == i_win[WIN_LEN-1]);

endmodule

`default_nettype wire

FILE: hw/rtl/range_frame_deframer.sv
// ---------------------------------------------------------------------------
// Range frame deframer
// Finds 16-byte sensor frames in a byte stream and emits their decoded fields.
// ---------------------------------------------------------------------------
// Usage: bytes of the sensor link enter on the input channel (i_rx_valid,
// o_rx_ready, i_rx_byte), one per transfer. They shift through a row of
// sixteen byte cells, the oldest byte in cell 0. Each time a window of
// sixteen bytes is held, the window is checked for the 0x57 / 0x00 header
// and the 8-bit additive checksum in the last byte. A passing window yields
// one result transfer on the output channel (o_res_valid, i_res_ready and
// the decoded fields), and its bytes are consumed, so the next check waits
// for sixteen new bytes. A failing window slides by one byte.
// Throughput is one byte per cycle while input is not held off. A result is
// loaded into the output register once the check pending after the frame's
// last byte passes and the output register is free.
// Reset clears the fill count, the pending check and the output valid; the
// byte cells are not cleared and are never checked before being refilled.
// When the receiver stalls, the output register holds its result and bytes
// keep flowing; input is held off only when a further passing frame meets
// a full output register, until that register is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module range_frame_deframer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire rfd_pkg::t_byte i_rx_byte,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output logic [7:0]         o_sensor_id,
    output logic [31:0]        o_system_time_ms,
    output logic [23:0]        o_distance_mm,
    output logic               o_distance_valid,
    output logic [15:0]        o_return_level,
    output logic [7:0]         o_range_prec
);
    import rfd_pkg::*;

    // Window held in the cell row; index 0 is the oldest byte.
    t_window     win;
    t_chk_status status;

    logic              rx_xfer;
    logic              out_free;
    logic              pass_now;
    logic              load_res;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_chk, n_chk;
    logic              r_res_valid, n_res_valid;

    logic [7:0]  r_sensor_id;
    logic [31:0] r_time;
    logic [23:0] r_dist;
    logic        r_dist_ok;
    logic [15:0] r_strength;
    logic [7:0]  r_prec;

    // The row of cells: each cell takes its right neighbor's byte on a
    // transfer, and the last cell takes the incoming byte.
    for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
        t_byte d_in;
        if (g == WIN_LEN - 1) begin : g_tail
            assign d_in = i_rx_byte;
        end else begin : g_body
            assign d_in = win[g+1];
        end
        rfd_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (rx_xfer),
            .i_d     (d_in),
            .o_q     (win[g])
        );
    end

    rfd_check u_check (
        .i_win    (win),
        .o_status (status)
    );

    // A check is pending for the window formed by the last transfer. It is
    // resolved in the cycle after, unless it passes while the output
    // register is still full; then the input stalls until it drains.
    assign out_free   = !r_res_valid || i_res_ready;
    assign pass_now   = r_chk && (r_fill == FILL_W'(WIN_LEN)) &&
                        status.hdr_ok && status.sum_ok;
    assign load_res   = pass_now && out_free;
    assign o_rx_ready = !(pass_now && !out_free);
    assign rx_xfer    = i_rx_valid && o_rx_ready;

    always_comb begin
        n_fill      = r_fill;
        n_chk       = r_chk;
        n_res_valid = r_res_valid;

        if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
        if (load_res) begin
            n_res_valid = 1'b1;
            n_fill      = '0;
        end
        if (rx_xfer) begin
            n_chk = 1'b1;
            if (n_fill != FILL_W'(WIN_LEN)) begin
                n_fill = n_fill + 1'b1;
            end
        end else if (r_chk && o_rx_ready) begin
            n_chk = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_chk       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_chk       <= n_chk;
            r_res_valid <= n_res_valid;
        end
    end

    // Decoded fields of a passing frame, multi-byte values little endian.
    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_sensor_id <= win[3];
            r_time      <= {win[7], win[6], win[5], win[4]};
            r_dist      <= {win[10], win[9], win[8]};
            r_dist_ok   <= (win[11] == STATUS_VALID);
            r_strength  <= {win[13], win[12]};
            r_prec      <= win[14];
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_sensor_id       = r_sensor_id;
    assign o_system_time_ms  = r_time;
    assign o_distance_mm     = r_dist;
    assign o_distance_valid  = r_dist_ok;
    assign o_return_level    = r_strength;
    assign o_range_prec      = r_prec;

    // The fill count never passes a full window.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_LEN))
        else $error("fill count beyond window length");

    // Input is held off only while the output register is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (r_res_valid && !i_res_ready))
        else $error("input stalled with a free output register");

    // A loaded result consumes the window: at most the concurrent byte remains.
    a_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_res |=> (r_fill <= FILL_W'(1) && r_res_valid))
        else $error("window not consumed after a result");

    // Every byte transfer leaves a check pending for the new window.
    a_chk_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer |=> r_chk)
        else $error("no check pending after a byte transfer");

endmodule

`default_nettype wire
